>>> rtl/ufr_pkg.sv
// Shared types, codes and the CRC16 step function of the update frame receiver.
package ufr_pkg;

    // Input command codes.
    localparam logic [2:0] CMD_BYTE    = 3'd0;
    localparam logic [2:0] CMD_FEND    = 3'd1;
    localparam logic [2:0] CMD_RXERR   = 3'd2;
    localparam logic [2:0] CMD_START   = 3'd3;
    localparam logic [2:0] CMD_END     = 3'd4;
    localparam logic [2:0] CMD_TIMEOUT = 3'd5;

    // Reply codes.
    localparam logic [2:0] RP_NONE     = 3'd0;
    localparam logic [2:0] RP_READY    = 3'd1;
    localparam logic [2:0] RP_OK       = 3'd2;
    localparam logic [2:0] RP_RETRY    = 3'd3;
    localparam logic [2:0] RP_NOTREADY = 3'd4;
    localparam logic [2:0] RP_RESTART  = 3'd5;

    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       store_byte;
        logic       set_overflow;
        logic       clear_frame;
        logic       open_image;
        logic       load_retries;
        logic       dec_retries;
        logic       rel_start;
        logic       rel_read;
        logic       rel_emit;
        logic       msg_load;
        logic [2:0] msg_reply;
        logic       msg_done;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_good;
        logic count_zero;
        logic count_full;
        logic retries_zero;
        logic image_match;
        logic rel_last;
    } t_dp_stat;

    // One result beat.
    typedef struct packed {
        logic       write_valid;
        logic [7:0] write_byte;
        logic [2:0] reply;
        logic       update_done;
        logic       last;
    } t_result;

    // Reflected CRC16 over one byte, one bit per step.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/ufr_if.sv
// Valid/ready channel interfaces for the input, result and configuration beats.
interface ufr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [7:0]  data_byte;
    logic [15:0] check_value;

    modport source (output valid, command, data_byte, check_value, input ready);
    modport sink (input valid, command, data_byte, check_value, output ready);
endinterface

interface ufr_out_if;
    logic       valid;
    logic       ready;
    logic       write_valid;
    logic [7:0] write_byte;
    logic [2:0] reply;
    logic       update_done;
    logic       last;

    modport source (output valid, write_valid, write_byte, reply, update_done, last,
                    input ready);
    modport sink (input valid, write_valid, write_byte, reply, update_done, last,
                  output ready);
endinterface

interface ufr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> rtl/ufr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ufr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ufr_datapath.sv
// Datapath: frame buffer, frame and image CRCs, retry counter and result register.
module ufr_datapath import ufr_pkg::*; #(
    parameter int FRAME_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_check_value,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    output t_dp_stat    o_stat,
    output t_result     o_res
);

    localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int CW = $clog2(FRAME_BYTES + 1);

    logic [7:0]    r_retry_limit;
    logic [7:0]    r_retries_left, n_retries_left;
    logic [15:0]   r_frame_crc, n_frame_crc;
    logic [15:0]   r_image_crc, n_image_crc;
    logic [CW-1:0] r_byte_count, n_byte_count;
    logic          r_overflow, n_overflow;
    logic [CW-1:0] r_rel_idx, n_rel_idx;
    logic [7:0]    rdata;
    t_result       r_res;

    ufr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store_byte),
        .i_waddr (r_byte_count[AW-1:0]),
        .i_wdata (i_data_byte),
        .i_re    (i_cmd.rel_read),
        .i_raddr (r_rel_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        n_retries_left = r_retries_left;
        n_frame_crc    = r_frame_crc;
        n_image_crc    = r_image_crc;
        n_byte_count   = r_byte_count;
        n_overflow     = r_overflow;
        n_rel_idx      = r_rel_idx;

        if (i_cmd.store_byte) begin
            n_frame_crc  = crc16_byte(r_frame_crc, i_data_byte);
            n_byte_count = CW'(r_byte_count + CW'(1));
        end
        if (i_cmd.set_overflow) begin
            n_overflow = 1'b1;
        end
        if (i_cmd.clear_frame || i_cmd.open_image) begin
            n_frame_crc  = CRC_INIT;
            n_byte_count = '0;
            n_overflow   = 1'b0;
        end
        if (i_cmd.open_image) begin
            n_image_crc = CRC_INIT;
        end
        if (i_cmd.rel_emit) begin
            n_image_crc = crc16_byte(r_image_crc, rdata);
            n_rel_idx   = CW'(r_rel_idx + CW'(1));
        end
        if (i_cmd.rel_start) begin
            n_rel_idx = '0;
        end
        if (i_cmd.load_retries || i_cmd.open_image) begin
            n_retries_left = r_retry_limit;
        end
        if (i_cmd.dec_retries) begin
            n_retries_left = r_retries_left - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit  <= RETRY_LIMIT_RESET;
            r_retries_left <= RETRY_LIMIT_RESET;
            r_frame_crc    <= CRC_INIT;
            r_image_crc    <= CRC_INIT;
            r_byte_count   <= '0;
            r_overflow     <= 1'b0;
            r_rel_idx      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_retry_limit <= i_cfg_data;
            end
            r_retries_left <= n_retries_left;
            r_frame_crc    <= n_frame_crc;
            r_image_crc    <= n_image_crc;
            r_byte_count   <= n_byte_count;
            r_overflow     <= n_overflow;
            r_rel_idx      <= n_rel_idx;
        end
    end

    // Result register: either a released buffer byte (the last one with the OK reply) or a single reply.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rel_emit) begin
            r_res.write_valid <= 1'b1;
            r_res.write_byte  <= rdata;
            r_res.reply       <= o_stat.rel_last ? RP_OK : RP_NONE;
            r_res.update_done <= 1'b0;
            r_res.last        <= o_stat.rel_last;
        end else if (i_cmd.msg_load) begin
            r_res.write_valid <= 1'b0;
            r_res.write_byte  <= 8'h00;
            r_res.reply       <= i_cmd.msg_reply;
            r_res.update_done <= i_cmd.msg_done;
            r_res.last        <= 1'b1;
        end
    end

    assign o_res = r_res;

    assign o_stat.frame_good   = !r_overflow && (r_frame_crc == i_check_value);
    assign o_stat.count_zero   = (r_byte_count == '0);
    assign o_stat.count_full   = (r_byte_count == CW'(FRAME_BYTES));
    assign o_stat.retries_zero = (r_retries_left == 8'd0);
    assign o_stat.image_match  = (r_image_crc == i_check_value);
    assign o_stat.rel_last     = (CW'(r_rel_idx + CW'(1)) == r_byte_count);

endmodule

>>> rtl/ufr_ctrl.sv
// Controller: image phase, command decode, buffer release sequencing and output valid.
module ufr_ctrl import ufr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_command,
    input  logic       i_out_ready,
    input  t_dp_stat   i_stat,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RECV = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       slot_free;
    logic       accept;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_ACCEPT) && slot_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_phase     = r_phase;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;

        unique case (r_state)
            ST_ACCEPT: begin
                if (accept && r_phase != PH_DONE && i_command <= CMD_TIMEOUT) begin
                    if (r_phase != PH_RECV) begin
                        if (i_command == CMD_START) begin
                            o_cmd.open_image = 1'b1;
                            o_cmd.msg_load   = 1'b1;
                            o_cmd.msg_reply  = RP_READY;
                            n_phase          = PH_RECV;
                        end else if (i_command == CMD_RXERR) begin
                            o_cmd.msg_load  = 1'b1;
                            o_cmd.msg_reply = RP_NOTREADY;
                        end
                    end else begin
                        unique case (i_command)
                            CMD_BYTE: begin
                                if (i_stat.count_full) begin
                                    o_cmd.set_overflow = 1'b1;
                                end else begin
                                    o_cmd.store_byte = 1'b1;
                                end
                            end
                            CMD_FEND, CMD_RXERR: begin
                                if (i_command == CMD_FEND && i_stat.frame_good) begin
                                    if (i_stat.count_zero) begin
                                        o_cmd.clear_frame  = 1'b1;
                                        o_cmd.load_retries = 1'b1;
                                        o_cmd.msg_load     = 1'b1;
                                        o_cmd.msg_reply    = RP_OK;
                                    end else begin
                                        // The frame is cleared once its last byte leaves.
                                        o_cmd.rel_start = 1'b1;
                                        n_state         = ST_READ;
                                    end
                                end else begin
                                    o_cmd.clear_frame = 1'b1;
                                    o_cmd.msg_load    = 1'b1;
                                    if (i_stat.retries_zero) begin
                                        o_cmd.msg_reply = RP_RESTART;
                                        n_phase         = PH_IDLE;
                                    end else begin
                                        o_cmd.msg_reply   = RP_RETRY;
                                        o_cmd.dec_retries = 1'b1;
                                    end
                                end
                            end
                            CMD_START: begin
                                o_cmd.open_image = 1'b1;
                                o_cmd.msg_load   = 1'b1;
                                o_cmd.msg_reply  = RP_READY;
                            end
                            CMD_END: begin
                                o_cmd.clear_frame = 1'b1;
                                o_cmd.msg_load    = 1'b1;
                                if (i_stat.image_match) begin
                                    o_cmd.msg_reply = RP_OK;
                                    o_cmd.msg_done  = 1'b1;
                                    n_phase         = PH_DONE;
                                end else begin
                                    o_cmd.msg_reply = RP_RESTART;
                                    n_phase         = PH_IDLE;
                                end
                            end
                            CMD_TIMEOUT: begin
                                o_cmd.clear_frame  = 1'b1;
                                o_cmd.load_retries = 1'b1;
                                o_cmd.msg_load     = 1'b1;
                                o_cmd.msg_reply    = RP_OK;
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (o_cmd.msg_load) begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rel_read = 1'b1;
                n_state        = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    o_cmd.rel_emit = 1'b1;
                    n_out_valid    = 1'b1;
                    if (i_stat.rel_last) begin
                        o_cmd.clear_frame  = 1'b1;
                        o_cmd.load_retries = 1'b1;
                        n_state            = ST_ACCEPT;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_state     <= ST_ACCEPT;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/update_frame_receiver_top.sv
// Update frame receiver: registered-result wrapper of controller, datapath and frame buffer.
// Replies: a beat that calls for one reply shows it on the output in the cycle after acceptance.
// Throughput: one input beat per cycle while the result register is free or being drained;
// a good frame of n bytes releases them one by one (buffer read, then emit once the result
// register is free) through the registered read port, and takes no input meanwhile.
// Reset: synchronous, active low; buffer contents stay undefined and need no clearing pass.
module update_frame_receiver_top import ufr_pkg::*; #(
    parameter int FRAME_BYTES = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ufr_in_if.sink    i_in,
    ufr_out_if.source o_out,
    ufr_cfg_if.sink   i_cfg
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_result  res;
    logic     cfg_we;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid && i_cfg.ready;

    ufr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_command   (i_in.command),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    ufr_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_in.data_byte),
        .i_check_value (i_in.check_value),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (i_cfg.data),
        .o_stat        (stat),
        .o_res         (res)
    );

    assign o_out.write_valid = res.write_valid;
    assign o_out.write_byte  = res.write_byte;
    assign o_out.reply       = res.reply;
    assign o_out.update_done = res.update_done;
    assign o_out.last        = res.last;

endmodule

>>> tb/update_frame_receiver_top_test.sv
// Self-checking testbench of update_frame_receiver_top: random framed image traffic, scoreboard.
module update_frame_receiver_top_test;
    import ufr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_BYTES   = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    // Command codes that the receiver does not define.
    localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    // Tracks the receiver's state beat by beat and holds the result beats it owes.
    class ufr_scoreboard;
        typedef enum logic [1:0] {ST_IDLE, ST_RECV, ST_DONE} t_stage;

        t_stage      stage;
        logic [7:0]  retry_limit;
        logic [7:0]  retries;
        logic [15:0] frame_crc;
        logic [15:0] image_crc;
        int unsigned frame_count;
        bit          frame_overflow;
        logic [7:0]  frame_bytes[BUF_BYTES];
        t_result     due_beats[$];
        int unsigned mismatches;

        function new();
            stage          = ST_IDLE;
            retry_limit    = RETRY_LIMIT_RESET;
            retries        = RETRY_LIMIT_RESET;
            frame_crc      = CRC_INIT;
            image_crc      = CRC_INIT;
            frame_count    = 0;
            frame_overflow = 1'b0;
            mismatches     = 0;
        endfunction

        // Bitwise form: the data bit is folded into the feedback instead of xored in first.
        static function logic [15:0] crc_update(logic [15:0] acc, logic [7:0] b);
            logic [15:0] r;
            r = acc;
            for (int k = 0; k < 8; k++) begin
                r = (r >> 1) ^ ((r[0] ^ b[k]) ? CRC_POLY : 16'h0000);
            end
            return r;
        endfunction

        function void owe(logic wv, logic [7:0] wb, logic [2:0] rp, logic done, logic fin);
            t_result beat;
            beat.write_valid = wv;
            beat.write_byte  = wb;
            beat.reply       = rp;
            beat.update_done = done;
            beat.last        = fin;
            due_beats.push_back(beat);
        endfunction

        function void drop_frame();
            frame_crc      = CRC_INIT;
            frame_count    = 0;
            frame_overflow = 1'b0;
        endfunction

        function void open_image();
            drop_frame();
            image_crc = CRC_INIT;
            retries   = retry_limit;
            stage     = ST_RECV;
        endfunction

        function void bad_frame();
            drop_frame();
            if (retries == 0) begin
                stage = ST_IDLE;
                owe(1'b0, 8'h00, RP_RESTART, 1'b0, 1'b1);
            end else begin
                retries = retries - 8'd1;
                owe(1'b0, 8'h00, RP_RETRY, 1'b0, 1'b1);
            end
        endfunction

        // Applies one accepted input beat; returns 1 unless the beat was ignored.
        function bit take_command(logic [2:0] cmd, logic [7:0] db, logic [15:0] chk);
            if (stage == ST_DONE || cmd > CMD_TIMEOUT) return 1'b0;
            if (stage != ST_RECV) begin
                if (cmd == CMD_START) begin
                    open_image();
                    owe(1'b0, 8'h00, RP_READY, 1'b0, 1'b1);
                    return 1'b1;
                end
                if (cmd == CMD_RXERR) begin
                    owe(1'b0, 8'h00, RP_NOTREADY, 1'b0, 1'b1);
                    return 1'b1;
                end
                return 1'b0;
            end
            case (cmd)
                CMD_BYTE: begin
                    if (frame_count < BUF_BYTES) begin
                        frame_bytes[frame_count] = db;
                        frame_crc = crc_update(frame_crc, db);
                        frame_count++;
                    end else begin
                        frame_overflow = 1'b1;
                    end
                end
                CMD_FEND: begin
                    if (frame_overflow || frame_crc != chk) begin
                        bad_frame();
                    end else begin
                        if (frame_count == 0) begin
                            owe(1'b0, 8'h00, RP_OK, 1'b0, 1'b1);
                        end
                        for (int i = 0; i < frame_count; i++) begin
                            image_crc = crc_update(image_crc, frame_bytes[i]);
                            if (i == frame_count - 1) begin
                                owe(1'b1, frame_bytes[i], RP_OK, 1'b0, 1'b1);
                            end else begin
                                owe(1'b1, frame_bytes[i], RP_NONE, 1'b0, 1'b0);
                            end
                        end
                        drop_frame();
                        retries = retry_limit;
                    end
                end
                CMD_RXERR: bad_frame();
                CMD_START: begin
                    open_image();
                    owe(1'b0, 8'h00, RP_READY, 1'b0, 1'b1);
                end
                CMD_END: begin
                    drop_frame();
                    if (image_crc == chk) begin
                        stage = ST_DONE;
                        owe(1'b0, 8'h00, RP_OK, 1'b1, 1'b1);
                    end else begin
                        stage = ST_IDLE;
                        owe(1'b0, 8'h00, RP_RESTART, 1'b0, 1'b1);
                    end
                end
                default: begin
                    drop_frame();
                    retries = retry_limit;
                    owe(1'b0, 8'h00, RP_OK, 1'b0, 1'b1);
                end
            endcase
            return 1'b1;
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 40) $display("ERROR at %0t: %s", $realtime, what);
        endtask

        task check_beat(t_result got);
            t_result want;
            if (due_beats.size() == 0) begin
                report($sformatf("result beat with nothing owed, reply %0d byte %02h",
                                 got.reply, got.write_byte));
                return;
            end
            want = due_beats.pop_front();
            if (got.write_valid !== want.write_valid)
                report($sformatf("write_valid %b, wanted %b", got.write_valid, want.write_valid));
            if (got.write_byte !== want.write_byte)
                report($sformatf("write_byte %02h, wanted %02h", got.write_byte, want.write_byte));
            if (got.reply !== want.reply)
                report($sformatf("reply %0d, wanted %0d", got.reply, want.reply));
            if (got.update_done !== want.update_done)
                report($sformatf("update_done %b, wanted %b", got.update_done, want.update_done));
            if (got.last !== want.last)
                report($sformatf("last %b, wanted %b", got.last, want.last));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    ufr_in_if  in_ch ();
    ufr_out_if out_ch ();
    ufr_cfg_if cfg_ch ();

    update_frame_receiver_top #(.FRAME_BYTES(BUF_BYTES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    ufr_scoreboard sb = new();
    bit            calm;
    bit            hold_request;
    int unsigned   applied;
    int unsigned   cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Result side: checks every accepted beat and stalls at random or for one long hold-off.
    initial begin
        int unsigned hold_left;
        t_result     got;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.write_valid = out_ch.write_valid;
                got.write_byte  = out_ch.write_byte;
                got.reply       = out_ch.reply;
                got.update_done = out_ch.update_done;
                got.last        = out_ch.last;
                sb.check_beat(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(0, 99) >= 27);
            end
        end
    end

    task automatic send_beat(input logic [2:0] cmd, input logic [7:0] db,
                             input logic [15:0] chk);
        while (!calm && $urandom_range(0, 99) < 27) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.command     <= cmd;
        in_ch.data_byte   <= db;
        in_ch.check_value <= chk;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        if (sb.take_command(cmd, db, chk)) applied++;
    endtask

    task automatic send_bytes(input int unsigned count);
        repeat (count) send_beat(CMD_BYTE, 8'($urandom_range(0, 255)),
                                 16'($urandom_range(0, 65535)));
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (sb.due_beats.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_retry_limit(input logic [7:0] limit);
        drain_results();
        // A quiet beat may still be in flight after the last owed result.
        repeat (8) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= limit;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        sb.retry_limit = limit;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [15:0] wrong_image_crc();
        return sb.image_crc ^ 16'($urandom_range(1, 65535));
    endfunction

    task automatic send_frame();
        int unsigned kind;
        int unsigned len;
        logic [2:0]  cmd;
        kind = $urandom_range(0, 99);
        len  = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 8) : $urandom_range(9, 63);
        if ($urandom_range(0, 49) == 0) len = BUF_BYTES;
        if (kind < 57) begin
            send_bytes(len);
            send_beat(CMD_FEND, 8'($urandom_range(0, 255)), sb.frame_crc);
        end else if (kind < 70) begin
            send_bytes($urandom_range(0, 8));
            send_beat(CMD_FEND, 8'($urandom_range(0, 255)),
                      sb.frame_crc ^ 16'($urandom_range(1, 65535)));
        end else if (kind < 73) begin
            // Too many bytes: the frame is bad even with the matching check value.
            send_bytes($urandom_range(BUF_BYTES + 1, BUF_BYTES + 6));
            send_beat(CMD_FEND, 8'($urandom_range(0, 255)), sb.frame_crc);
        end else if (kind < 81) begin
            send_bytes($urandom_range(0, 5));
            send_beat(CMD_RXERR, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        end else if (kind < 87) begin
            send_bytes($urandom_range(0, 5));
            send_beat(CMD_TIMEOUT, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        end else if (kind < 91) begin
            send_bytes($urandom_range(0, 4));
            send_beat(CMD_START, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        end else begin
            repeat ($urandom_range(1, 3)) begin
                cmd = 3'($urandom_range(0, 7));
                send_beat(cmd, 8'($urandom_range(0, 255)),
                          (cmd == CMD_END) ? wrong_image_crc() : 16'($urandom_range(0, 65535)));
            end
        end
    endtask

    // Image sessions that never pass the final check, so the receiver stays usable.
    task automatic run_sessions(input int unsigned budget);
        int unsigned stop_at;
        stop_at = applied + budget;
        while (applied < stop_at) begin
            if ($urandom_range(0, 9) == 0)
                send_beat(CMD_RXERR, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            send_beat(CMD_START, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            repeat ($urandom_range(1, 6)) send_frame();
            if ($urandom_range(0, 3) != 0)
                send_beat(CMD_END, 8'($urandom_range(0, 255)), wrong_image_crc());
        end
    endtask

    initial begin
        calm         = 1'b0;
        hold_request = 1'b0;
        applied      = 0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.command     <= CMD_BYTE;
        in_ch.data_byte   <= 8'h00;
        in_ch.check_value <= 16'h0000;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Idle: only a start marker or a receive error gets an answer.
        send_beat(CMD_BYTE, 8'hFF, 16'hFFFF);
        send_beat(CMD_FEND, 8'h00, 16'hFFFF);
        send_beat(CMD_END, 8'hFF, 16'hFFFF);
        send_beat(CMD_TIMEOUT, 8'h00, 16'h0000);
        send_beat(CMD_UNUSED_LO, 8'hFF, 16'hFFFF);
        send_beat(CMD_UNUSED_HI, 8'h00, 16'h0000);
        send_beat(CMD_RXERR, 8'hFF, 16'h0000);
        send_beat(CMD_START, 8'h00, 16'hFFFF);
        // Empty good frame, then a two byte frame at the byte extremes.
        send_beat(CMD_FEND, 8'h00, sb.frame_crc);
        send_beat(CMD_BYTE, 8'h00, 16'h0000);
        send_beat(CMD_BYTE, 8'hFF, 16'hFFFF);
        send_beat(CMD_FEND, 8'hFF, sb.frame_crc);
        send_beat(CMD_FEND, 8'h00, 16'h0000);
        send_beat(CMD_BYTE, 8'hA5, 16'h0000);
        send_beat(CMD_RXERR, 8'h00, 16'hFFFF);
        send_beat(CMD_BYTE, 8'h5A, 16'h5A5A);
        send_beat(CMD_TIMEOUT, 8'hFF, 16'hFFFF);
        send_beat(CMD_BYTE, 8'h81, 16'h0000);
        send_beat(CMD_START, 8'h00, 16'h0000);
        send_beat(CMD_BYTE, 8'h7E, 16'hFFFF);
        send_beat(CMD_FEND, 8'h00, sb.frame_crc);
        send_beat(CMD_UNUSED_LO, 8'h00, 16'h0000);
        send_beat(CMD_UNUSED_HI, 8'hFF, 16'hFFFF);
        send_beat(CMD_END, 8'h00, wrong_image_crc());

        // No retries: the first bad frame restarts the update.
        write_retry_limit(8'd0);
        run_sessions(55);

        write_retry_limit(8'd255);
        calm = 1'b1;
        run_sessions(35);
        calm = 1'b0;
        run_sessions(30);

        // Long result stall while input keeps coming, then a full drain mid-stream.
        write_retry_limit(8'($urandom_range(1, 4)));
        hold_request = 1'b1;
        run_sessions(40);
        drain_results();
        run_sessions(35);

        write_retry_limit(8'($urandom_range(0, 255)));
        run_sessions(55);

        // The one image that passes; everything after it is ignored.
        send_beat(CMD_START, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        send_bytes(3);
        send_beat(CMD_FEND, 8'($urandom_range(0, 255)), sb.frame_crc);
        send_beat(CMD_END, 8'($urandom_range(0, 255)), sb.image_crc);
        send_beat(CMD_START, 8'h00, 16'h0000);
        send_beat(CMD_RXERR, 8'hFF, 16'hFFFF);
        send_beat(CMD_BYTE, 8'h3C, 16'h0000);
        send_beat(CMD_TIMEOUT, 8'h00, 16'h0000);

        drain_results();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
